// ----- src/ttv_pkg.sv -----
// ttv_pkg: widths, constants and shared types of the triangle tangent pipeline
// no dependencies; used by ttv_isqrt, ttv_div and triangle_tangent_vector
package ttv_pkg;

  localparam int unsigned COMP_W  = 16;   // one packed vector component
  localparam int unsigned LANES   = 3;    // x, y, z
  localparam int unsigned THR_W   = 16;
  localparam logic [15:0] THR_RESET = 16'd17;
  localparam int unsigned NORM_BL = 30;   // bit length of the largest component after scaling
  localparam int unsigned MAG_W   = 31;   // scaled magnitude, up to 2^30
  localparam int unsigned SQ_W    = 62;   // sum of three squares
  localparam int unsigned ROOT_W  = 31;
  localparam int unsigned QUO_W   = 15;   // quotient, up to 16384
  localparam int unsigned REM_W   = 46;
  localparam int unsigned UNIT    = 16384; // 1.0 in Q1.14

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             degen;
    logic             zero;
  } flags_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    flags_t                      flags;
  } sq_tag_t;

endpackage

// ----- src/ttv_isqrt.sv -----
// ttv_isqrt: pipelined integer square root, one root bit per stage
// depends on ttv_pkg; sideband word rides along with each radicand
module ttv_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ttv_pkg::SQ_W-1:0]    rad_i,
  input  ttv_pkg::sq_tag_t            tag_i,
  output logic                        valid_o,
  output logic [ttv_pkg::ROOT_W-1:0]  root_o,
  output ttv_pkg::sq_tag_t            tag_o
);

  localparam int unsigned SqW  = ttv_pkg::SQ_W;
  localparam int unsigned Iter = SqW / 2;

  logic [SqW-1:0]   x_q   [Iter];
  logic [SqW-1:0]   r_q   [Iter];
  ttv_pkg::sq_tag_t tag_q [Iter];
  logic [Iter-1:0]  vld_q;

  logic [SqW-1:0]   x_in   [Iter];
  logic [SqW-1:0]   r_in   [Iter];
  ttv_pkg::sq_tag_t tag_in [Iter];
  logic [Iter-1:0]  vld_in;
  logic [SqW-1:0]   x_d    [Iter];
  logic [SqW-1:0]   r_d    [Iter];

  always_comb begin
    x_in[0]   = rad_i;
    r_in[0]   = '0;
    tag_in[0] = tag_i;
    vld_in[0] = valid_i;
    for (int k = 1; k < Iter; k++) begin
      x_in[k]   = x_q[k-1];
      r_in[k]   = r_q[k-1];
      tag_in[k] = tag_q[k-1];
      vld_in[k] = vld_q[k-1];
    end
  end

  always_comb begin
    logic [SqW-1:0] step_bit;
    logic [SqW-1:0] trial;
    for (int k = 0; k < Iter; k++) begin
      step_bit = SqW'(1) << (SqW - 2 - 2 * k);
      trial    = r_in[k] + step_bit;
      if (x_in[k] >= trial) begin
        x_d[k] = x_in[k] - trial;
        r_d[k] = (r_in[k] >> 1) + step_bit;
      end else begin
        x_d[k] = x_in[k];
        r_d[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Iter; k++) begin
      x_q[k]   <= x_d[k];
      r_q[k]   <= r_d[k];
      tag_q[k] <= tag_in[k];
    end
  end

  assign valid_o = vld_q[Iter-1];
  assign root_o  = r_q[Iter-1][ttv_pkg::ROOT_W-1:0];
  assign tag_o   = tag_q[Iter-1];

endmodule

// ----- src/ttv_div.sv -----
// ttv_div: three-lane pipelined restoring divider, one quotient bit per stage
// depends on ttv_pkg; forms round(mag * 2^14 / len) for each lane
module ttv_div (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  logic [ttv_pkg::ROOT_W-1:0]                      len_i,
  input  ttv_pkg::sq_tag_t                                tag_i,
  output logic                                            valid_o,
  output logic [ttv_pkg::LANES-1:0][ttv_pkg::QUO_W-1:0]   quo_o,
  output ttv_pkg::flags_t                                 flags_o
);

  localparam int unsigned RemW  = ttv_pkg::REM_W;
  localparam int unsigned QuoW  = ttv_pkg::QUO_W;
  localparam int unsigned Lanes = ttv_pkg::LANES;
  localparam int unsigned LenW  = ttv_pkg::ROOT_W;

  logic [Lanes-1:0][RemW-1:0] rem_q  [QuoW];
  logic [Lanes-1:0][QuoW-1:0] quo_q  [QuoW];
  logic [LenW-1:0]            den_q  [QuoW];
  ttv_pkg::flags_t            flg_q  [QuoW];
  logic [QuoW-1:0]            vld_q;

  logic [Lanes-1:0][RemW-1:0] rem_in [QuoW];
  logic [Lanes-1:0][QuoW-1:0] quo_in [QuoW];
  logic [LenW-1:0]            den_in [QuoW];
  ttv_pkg::flags_t            flg_in [QuoW];
  logic [QuoW-1:0]            vld_in;
  logic [Lanes-1:0][RemW-1:0] rem_d  [QuoW];
  logic [Lanes-1:0][QuoW-1:0] quo_d  [QuoW];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      // dividend carries the half-divisor for rounding
      rem_in[0][l] = (RemW'(tag_i.mag[l]) << (QuoW - 1)) + RemW'(len_i >> 1);
    end
    quo_in[0] = '0;
    den_in[0] = len_i;
    flg_in[0] = tag_i.flags;
    vld_in[0] = valid_i;
    for (int k = 1; k < QuoW; k++) begin
      rem_in[k] = rem_q[k-1];
      quo_in[k] = quo_q[k-1];
      den_in[k] = den_q[k-1];
      flg_in[k] = flg_q[k-1];
      vld_in[k] = vld_q[k-1];
    end
  end

  always_comb begin
    logic [RemW-1:0] dsh;
    logic            ge;
    for (int k = 0; k < QuoW; k++) begin
      dsh = RemW'(den_in[k]) << (QuoW - 1 - k);
      for (int l = 0; l < Lanes; l++) begin
        ge          = rem_in[k][l] >= dsh;
        rem_d[k][l] = ge ? rem_in[k][l] - dsh : rem_in[k][l];
        quo_d[k][l] = {quo_in[k][l][QuoW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QuoW; k++) begin
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
      den_q[k] <= den_in[k];
      flg_q[k] <= flg_in[k];
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign flags_o = flg_q[QuoW-1];

endmodule

// ----- src/triangle_tangent_vector.sv -----
// triangle_tangent_vector: per-triangle unit tangent in fixed point, fully pipelined
// depends on ttv_pkg, ttv_isqrt and ttv_div
//
//   channel   handshake                  payload
//   command   start_i / busy_o           corner_pos_*_i, uv_*_i, normal_a_i
//   result    done_o (one-cycle strobe)  tangent_out_o, degenerate_o
//   config    cfg_valid_i / cfg_ready_o  cfg_data_i (det_threshold)
//
// one triangle per cycle; busy_o stays low and every word enters the pipe.
// the pipe holds 13 arithmetic stages, 31 square-root stages (one root bit
// each), 15 divider stages (one quotient bit each) and the output register.
// reset clears the valid bits and loads the threshold with 17.
// the receiver cannot stall, so results leave in order the cycle they finish.
module triangle_tangent_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [47:0] corner_pos_a_i,
  input  logic [47:0] corner_pos_b_i,
  input  logic [47:0] corner_pos_c_i,
  input  logic [31:0] uv_a_i,
  input  logic [31:0] uv_b_i,
  input  logic [31:0] uv_c_i,
  input  logic [47:0] normal_a_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ttv_pkg::THR_W-1:0] cfg_data_i,
  output logic        done_o,
  output logic [47:0] tangent_out_o,
  output logic        degenerate_o
);

  localparam logic [5:0] NormBl = 6'(ttv_pkg::NORM_BL);
  localparam logic [ttv_pkg::QUO_W-1:0] Unit = ttv_pkg::QUO_W'(ttv_pkg::UNIT);

  function automatic logic signed [16:0] comp17(input logic [47:0] w, input int k);
    logic [15:0] c;
    c = w[16*k +: 16];
    return {c[15], c};
  endfunction

  function automatic logic [5:0] bitlen(input logic [42:0] m);
    logic [5:0] bl;
    bl = '0;
    for (int i = 0; i < 43; i++) begin
      if (m[i]) bl = 6'(i + 1);
    end
    return bl;
  endfunction

  logic [ttv_pkg::THR_W-1:0] thr_q;
  logic [12:0] vld_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ttv_pkg::THR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      vld_q <= {vld_q[11:0], start_i};
    end
  end

  // stage 1: edges and uv deltas
  logic signed [16:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [15:0] n1_q [3];

  always_ff @(posedge clk_i) begin
    du1_q <= comp17({16'b0, uv_b_i}, 0) - comp17({16'b0, uv_a_i}, 0);
    dv1_q <= comp17({16'b0, uv_b_i}, 1) - comp17({16'b0, uv_a_i}, 1);
    du2_q <= comp17({16'b0, uv_c_i}, 0) - comp17({16'b0, uv_a_i}, 0);
    dv2_q <= comp17({16'b0, uv_c_i}, 1) - comp17({16'b0, uv_a_i}, 1);
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= comp17(corner_pos_b_i, i) - comp17(corner_pos_a_i, i);
      e2_q[i] <= comp17(corner_pos_c_i, i) - comp17(corner_pos_a_i, i);
      n1_q[i] <= normal_a_i[16*i +: 16];
    end
  end

  // stage 2: determinant and unscaled tangent
  logic signed [33:0] pdet_a, pdet_b;
  logic signed [33:0] pt_a [3];
  logic signed [33:0] pt_b [3];
  logic signed [34:0] det_q;
  logic signed [34:0] t2_q [3];
  logic signed [15:0] n2_q [3];

  always_comb begin
    pdet_a = du1_q * dv2_q;
    pdet_b = dv1_q * du2_q;
    for (int i = 0; i < 3; i++) begin
      pt_a[i] = e1_q[i] * du2_q;
      pt_b[i] = e2_q[i] * du1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    det_q <= {pdet_a[33], pdet_a} - {pdet_b[33], pdet_b};
    for (int i = 0; i < 3; i++) begin
      t2_q[i] <= {pt_a[i][33], pt_a[i]} - {pt_b[i][33], pt_b[i]};
      n2_q[i] <= n1_q[i];
    end
  end

  // stage 3: threshold test, sign of det folded into the tangent
  logic [34:0] det_mag;
  logic signed [35:0] tn3_q [3];
  logic signed [15:0] n3_q [3];
  logic dg3_q;

  assign det_mag = det_q[34] ? 35'(-det_q) : det_q;

  always_ff @(posedge clk_i) begin
    dg3_q <= det_mag < 35'(thr_q);
    for (int i = 0; i < 3; i++) begin
      tn3_q[i] <= det_q[34] ? -{t2_q[i][34], t2_q[i]} : {t2_q[i][34], t2_q[i]};
      n3_q[i]  <= n2_q[i];
    end
  end

  // stage 4: t . n products
  logic signed [51:0] tp_d  [3];
  logic signed [51:0] tp4_q [3];
  logic signed [35:0] tn4_q [3];
  logic signed [15:0] n4_q  [3];
  logic dg4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) tp_d[i] = tn3_q[i] * n3_q[i];
  end

  always_ff @(posedge clk_i) begin
    dg4_q <= dg3_q;
    for (int i = 0; i < 3; i++) begin
      tp4_q[i] <= tp_d[i];
      tn4_q[i] <= tn3_q[i];
      n4_q[i]  <= n3_q[i];
    end
  end

  // stage 5: rounded projection length
  logic signed [53:0] dot, dot_r;
  logic signed [39:0] c5_q;
  logic signed [35:0] tn5_q [3];
  logic signed [15:0] n5_q  [3];
  logic dg5_q;

  assign dot   = tp4_q[0] + tp4_q[1] + tp4_q[2];
  assign dot_r = dot + 54'sd8192;

  always_ff @(posedge clk_i) begin
    c5_q  <= dot_r[53:14];
    dg5_q <= dg4_q;
    for (int i = 0; i < 3; i++) begin
      tn5_q[i] <= tn4_q[i];
      n5_q[i]  <= n4_q[i];
    end
  end

  // stage 6: normal times projection length
  logic signed [55:0] nc_d  [3];
  logic signed [55:0] nc6_q [3];
  logic signed [35:0] tn6_q [3];
  logic dg6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) nc_d[i] = n5_q[i] * c5_q;
  end

  always_ff @(posedge clk_i) begin
    dg6_q <= dg5_q;
    for (int i = 0; i < 3; i++) begin
      nc6_q[i] <= nc_d[i];
      tn6_q[i] <= tn5_q[i];
    end
  end

  // stage 7: remove the normal part
  logic signed [55:0] nc_r [3];
  logic signed [42:0] p_d  [3];
  logic signed [42:0] p7_q [3];
  logic dg7_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nc_r[i] = nc6_q[i] + 56'sd8192;
      p_d[i]  = tn6_q[i] - $signed(nc_r[i][55:14]);
    end
  end

  always_ff @(posedge clk_i) begin
    dg7_q <= dg6_q;
    for (int i = 0; i < 3; i++) p7_q[i] <= p_d[i];
  end

  // stage 8: largest magnitude
  logic [42:0] pm [3];
  logic [42:0] m_d;
  logic [42:0] m8_q;
  logic signed [42:0] p8_q [3];
  logic dg8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) pm[i] = p7_q[i][42] ? 43'(-p7_q[i]) : p7_q[i];
    m_d = pm[0];
    if (pm[1] > m_d) m_d = pm[1];
    if (pm[2] > m_d) m_d = pm[2];
  end

  always_ff @(posedge clk_i) begin
    m8_q  <= m_d;
    dg8_q <= dg7_q;
    for (int i = 0; i < 3; i++) p8_q[i] <= p7_q[i];
  end

  // stage 9: bit length of the largest magnitude
  logic [5:0] bl9_q;
  logic signed [42:0] p9_q [3];
  logic dg9_q, zr9_q;

  always_ff @(posedge clk_i) begin
    bl9_q <= bitlen(m8_q);
    zr9_q <= m8_q == '0;
    dg9_q <= dg8_q;
    for (int i = 0; i < 3; i++) p9_q[i] <= p8_q[i];
  end

  // stage 10: scale to a fixed bit length, floor on the right shift
  logic signed [42:0] sh [3];
  logic signed [31:0] pn10_q [3];
  logic dg10_q, zr10_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl9_q > NormBl) sh[i] = p9_q[i] >>> (bl9_q - NormBl);
      else                sh[i] = p9_q[i] <<< (NormBl - bl9_q);
    end
  end

  always_ff @(posedge clk_i) begin
    dg10_q <= dg9_q;
    zr10_q <= zr9_q;
    for (int i = 0; i < 3; i++) pn10_q[i] <= sh[i][31:0];
  end

  // stage 11: magnitudes and signs
  ttv_pkg::sq_tag_t tag11_q;
  logic [31:0] pn_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) pn_mag[i] = pn10_q[i][31] ? 32'(-pn10_q[i]) : pn10_q[i];
  end

  always_ff @(posedge clk_i) begin
    tag11_q.flags.degen <= dg10_q;
    tag11_q.flags.zero  <= zr10_q;
    for (int i = 0; i < 3; i++) begin
      tag11_q.mag[i]       <= pn_mag[i][ttv_pkg::MAG_W-1:0];
      tag11_q.flags.neg[i] <= pn10_q[i][31];
    end
  end

  // stage 12: squares
  logic [ttv_pkg::SQ_W-1:0] sq12_q [3];
  ttv_pkg::sq_tag_t tag12_q;

  always_ff @(posedge clk_i) begin
    tag12_q <= tag11_q;
    for (int i = 0; i < 3; i++) begin
      sq12_q[i] <= ttv_pkg::SQ_W'(tag11_q.mag[i]) * ttv_pkg::SQ_W'(tag11_q.mag[i]);
    end
  end

  // stage 13: sum of squares
  logic [ttv_pkg::SQ_W-1:0] sum13_q;
  ttv_pkg::sq_tag_t tag13_q;

  always_ff @(posedge clk_i) begin
    sum13_q <= sq12_q[0] + sq12_q[1] + sq12_q[2];
    tag13_q <= tag12_q;
  end

  logic sq_valid;
  logic [ttv_pkg::ROOT_W-1:0] len;
  ttv_pkg::sq_tag_t sq_tag;

  ttv_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[12]),
    .rad_i   (sum13_q),
    .tag_i   (tag13_q),
    .valid_o (sq_valid),
    .root_o  (len),
    .tag_o   (sq_tag)
  );

  logic div_valid;
  logic [ttv_pkg::LANES-1:0][ttv_pkg::QUO_W-1:0] quo;
  ttv_pkg::flags_t div_flags;

  ttv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .len_i   (len),
    .tag_i   (sq_tag),
    .valid_o (div_valid),
    .quo_o   (quo),
    .flags_o (div_flags)
  );

  // output word: clamp to one, apply sign, zero when degenerate or vanishing
  logic [47:0] tang_d;
  logic [ttv_pkg::QUO_W-1:0] qc;
  logic [15:0] qs;
  logic done_q, deg_q;
  logic [47:0] tang_q;

  always_comb begin
    tang_d = '0;
    for (int i = 0; i < 3; i++) begin
      qc = (quo[i] > Unit) ? Unit : quo[i];
      qs = div_flags.neg[i] ? -{1'b0, qc} : {1'b0, qc};
      if (!div_flags.degen && !div_flags.zero) tang_d[16*i +: 16] = qs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tang_q <= tang_d;
    deg_q  <= div_flags.degen;
  end

  assign done_o        = done_q;
  assign tangent_out_o = tang_q;
  assign degenerate_o  = deg_q;

endmodule

// ----- verif/tb_triangle_tangent_vector.sv -----
// tb_triangle_tangent_vector: random and directed regression of the tangent pipeline
// depends on ttv_pkg and triangle_tangent_vector; a built-in fixed-point predictor
`timescale 1ns / 1ps

class tangent_scoreboard;
  logic [47:0] exp_tangent[$];
  logic        exp_degen[$];
  logic [15:0] det_thr;
  int          errors;
  int          n_degen;
  int          n_checked;

  function new();
    det_thr = ttv_pkg::THR_RESET;
    errors = 0;
    n_degen = 0;
    n_checked = 0;
  endfunction

  function longint comp(logic [47:0] w, int k);
    return longint'($signed(w[16*k +: 16]));
  endfunction

  function longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // append one expected word to the tail of the queues
  function void enqueue(logic [47:0] tang, logic degen);
    exp_tangent = {exp_tangent, tang};
    exp_degen   = {exp_degen, degen};
  endfunction

  // note an accepted triangle and queue its expected tangent
  function void note_triangle(logic [47:0] pa, logic [47:0] pb, logic [47:0] pc,
                              logic [31:0] ua, logic [31:0] ub, logic [31:0] uc,
                              logic [47:0] nrm);
    longint du1, dv1, du2, dv2, det, dot, c, m, len, sumsq, q;
    longint t[3], p[3], n[3];
    logic [47:0] tang;
    int bl;
    du1 = comp(ub, 0) - comp(ua, 0);
    dv1 = comp(ub, 1) - comp(ua, 1);
    du2 = comp(uc, 0) - comp(ua, 0);
    dv2 = comp(uc, 1) - comp(ua, 1);
    det = du1 * dv2 - dv1 * du2;
    tang = '0;
    if ((det < 0 ? -det : det) < longint'(det_thr)) begin
      enqueue('0, 1'b1);
      n_degen++;
      return;
    end
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = comp(nrm, i);
      t[i] = (comp(pb, i) - comp(pa, i)) * du2 - (comp(pc, i) - comp(pa, i)) * du1;
      if (det < 0) t[i] = -t[i];
      dot += t[i] * n[i];
    end
    c = round_sh(dot, 14);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = t[i] - round_sh(n[i] * c, 14);
      if ((p[i] < 0 ? -p[i] : p[i]) > m) m = p[i] < 0 ? -p[i] : p[i];
    end
    if (m != 0) begin
      bl = 0;
      while (bl < 63 && (m >> bl) != 0) bl++;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        if (bl > 30) p[i] = floor_sh(p[i], bl - 30);
        else p[i] = p[i] * (longint'(1) << (30 - bl));
        sumsq += p[i] * p[i];
      end
      len = longint'(root64(longint'(sumsq)));
      for (int i = 0; i < 3; i++) begin
        q = ((p[i] < 0 ? -p[i] : p[i]) * 16384 + len / 2) / len;
        if (q > ttv_pkg::UNIT) q = ttv_pkg::UNIT;
        tang[16*i +: 16] = p[i] < 0 ? 16'(-q) : 16'(q);
      end
    end
    enqueue(tang, 1'b0);
  endfunction

  function void check_result(logic [47:0] tang, logic degen);
    logic [47:0] et;
    logic ed;
    if (exp_tangent.size() == 0) begin
      $error("result with no triangle pending: tangent %h", tang);
      errors++;
      return;
    end
    et = exp_tangent.pop_front();
    ed = exp_degen.pop_front();
    n_checked++;
    if (tang !== et) begin
      $error("tangent_out: expected %h, actual %h", et, tang);
      errors++;
    end
    if (degen !== ed) begin
      $error("degenerate: expected %b, actual %b", ed, degen);
      errors++;
    end
  endfunction
endclass

module tb_triangle_tangent_vector;
  localparam int LATENCY = 60;
  localparam int STALL_LIMIT = 2000;

  logic clk_i, rst_ni, start_i, busy_o, cfg_valid_i, cfg_ready_o, done_o, degenerate_o;
  logic [47:0] corner_pos_a_i, corner_pos_b_i, corner_pos_c_i, normal_a_i, tangent_out_o;
  logic [31:0] uv_a_i, uv_b_i, uv_c_i;
  logic [ttv_pkg::THR_W-1:0] cfg_data_i;

  tangent_scoreboard tangents;
  int idle_pct;
  int quiet_cycles;
  int n_sent;

  triangle_tangent_vector dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tangents.check_result(tangent_out_o, degenerate_o);
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("triangle_tangent_vector regression: fail");
        $finish;
      end
    end
  end

  task automatic write_threshold(logic [15:0] thr);
    start_i <= 1'b0;
    // pipeline has no idle flag; let the last words drain
    while (tangents.exp_tangent.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    tangents.det_thr = thr;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_triangle(logic [47:0] pa, logic [47:0] pb, logic [47:0] pc,
                               logic [31:0] ua, logic [31:0] ub, logic [31:0] uc,
                               logic [47:0] nrm);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    corner_pos_a_i <= pa;
    corner_pos_b_i <= pb;
    corner_pos_c_i <= pc;
    uv_a_i         <= ua;
    uv_b_i         <= ub;
    uv_c_i         <= uc;
    normal_a_i     <= nrm;
    do @(posedge clk_i); while (busy_o);
    tangents.note_triangle(pa, pb, pc, ua, ub, uc, nrm);
    n_sent++;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // small components keep positions and uv near each other, as on real meshes
  function automatic logic [15:0] near(logic [15:0] base, int span);
    return base + 16'($urandom_range(2 * span) - span);
  endfunction

  task automatic random_triangle();
    logic [47:0] pa, pb, pc, nrm;
    logic [31:0] ua, ub, uc;
    int k, span;
    k = $urandom_range(9);
    if (k < 2) begin
      pa = rand48(); pb = rand48(); pc = rand48(); nrm = rand48();
      ua = $urandom; ub = $urandom; uc = $urandom;
    end else begin
      span = (k < 5) ? 64 : 4000;
      pa = rand48();
      for (int i = 0; i < 3; i++) begin
        pb[16*i +: 16] = near(pa[16*i +: 16], span);
        pc[16*i +: 16] = near(pa[16*i +: 16], span);
      end
      ua = $urandom;
      span = (k == 9) ? 3 : 2000;
      for (int i = 0; i < 2; i++) begin
        ub[16*i +: 16] = near(ua[16*i +: 16], span);
        uc[16*i +: 16] = near(ua[16*i +: 16], span);
      end
      // mostly unit-ish normals, sometimes arbitrary
      nrm = ($urandom_range(3) == 0) ? rand48()
          : {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
             16'($urandom_range(32768) - 16384)};
    end
    send_triangle(pa, pb, pc, ua, ub, uc, nrm);
  endtask

  initial begin
    tangents = new();
    quiet_cycles = 0;
    n_sent = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    corner_pos_a_i = '0; corner_pos_b_i = '0; corner_pos_c_i = '0;
    uv_a_i = '0; uv_b_i = '0; uv_c_i = '0; normal_a_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain triangle, swapped corners, non-unit normal, extremes
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_1000, 32'h1000_0000, 48'h4000_0000_0000);
    send_triangle(48'h0, 48'h0000_0100_0000, 48'h0000_0000_0100,
                  32'h0, 32'h0000_1000, 32'h1000_0000, 48'h4000_0000_0000);
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_1000, 32'h1000_0000, 48'h7fff_7fff_7fff);
    send_triangle(48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h8000_7fff_8000,
                  32'h8000_8000, 32'h7fff_7fff, 32'h7fff_8000, 48'h8000_8000_8000);
    send_triangle(48'hffff_ffff_ffff, 48'h0, 48'h1234_8000_7fff,
                  32'hffff_ffff, 32'h0, 32'h8000_7fff, 48'hffff_ffff_ffff);
    // tangent along the normal vanishes
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0000_0100,
                  32'h0, 32'h0000_1000, 32'h1000_0000, 48'h0000_0000_4000);
    // zero det: degenerate
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_1000, 32'h0000_2000, 48'h4000_0000_0000);
    // det of 16, just under the reset threshold, and 17 just at it
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_0004, 32'h0004_0000, 48'h0);
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_0011, 32'h0001_0000, 48'h0);
    write_threshold(16'd0);
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_1000, 32'h0000_2000, 48'h4000_0000_0000);
    send_triangle(48'h0, 48'h0, 48'h0, 32'h0, 32'h0, 32'h0, 48'h0);
    write_threshold(16'hffff);
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_00ff, 32'h0100_0000, 48'h4000_0000_0000);
    send_triangle(48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                  32'h0, 32'h0000_0100, 32'h0100_0000, 48'h4000_0000_0000);

    // random phases: sender idle 17%, then 59%, then never
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 59 : 0;
      write_threshold(ph == 0 ? 16'd17 : ph == 1 ? 16'(1 + $urandom_range(65534)) : 16'd0);
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(40) == 0) begin
          start_i <= 1'b0;
          repeat (1 + $urandom_range(5)) @(posedge clk_i);
        end
        random_triangle();
      end
    end
    start_i <= 1'b0;

    while (tangents.exp_tangent.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("covered %0d triangles over six threshold settings, %0d degenerate",
             n_sent, tangents.n_degen);
    if (tangents.errors == 0 && tangents.n_checked == n_sent)
      $display("triangle_tangent_vector regression: pass");
    else
      $display("triangle_tangent_vector regression: fail");
    $finish;
  end
endmodule
